@@ rtl/core/tpdbf_pkg.sv @@
// shared widths, register indexes and defaults of the bond finder
package tpdbf_pkg;

	localparam int MAX_ATOMS_DEF  = 64;
	localparam int COORD_BITS_DEF = 20;

	localparam int TYPE_W    = 8;
	localparam int RAD_W     = 19;
	localparam int IDX_OUT_W = 6;
	localparam int NUM_W     = 12;
	localparam int CFG_IDX_W = 3;

	localparam logic [NUM_W-1:0] BOND_MAX = 12'd4095;

	localparam logic [CFG_IDX_W-1:0] CFG_BOND_KIND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS = 3'd4;

endpackage

@@ rtl/core/typed_pair_distance_bond_finder.sv @@
// top level of the typed pair distance bond finder
//
// Atoms come in on the in_valid/in_ready channel, one item each, and are kept
// in a ring of MAX_ATOMS cells. For every accepted atom the ring turns once,
// one stored atom a cycle while the output does not stall, past a three-stage
// pair test; in_ready stays low through the SCAN, DRAIN and FLUSH states, so a
// new atom is taken only once the last is through, and the ring length sets
// the scan length. An atom that finds the store full is taken without a scan.
// Each bond found leaves on the out_valid/out_ready channel as one item. One
// bond is held back until the next one is found or the scan ends, so that the
// last bond of an atom carries last_of_run; bonds appear in order of the
// earlier atom.
// When the receiver stalls with an item waiting, the ring and the pair test
// stop until that item is taken, so nothing is lost.
// Configuration writes enter through cfg_we, cfg_index and cfg_data; they are
// to be made while no atom is in work, which the block itself does not enforce.
// Reset zeroes the atom and bond counts, configuration, sequencer and output;
// the stored atoms are not cleared and are only read below the atom count.
module typed_pair_distance_bond_finder #(
	parameter int MAX_ATOMS  = tpdbf_pkg::MAX_ATOMS_DEF,
	parameter int COORD_BITS = tpdbf_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tpdbf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpdbf_pkg::RAD_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [tpdbf_pkg::TYPE_W-1:0]         atom_type,
	input  logic signed [COORD_BITS-1:0]         pos_x,
	input  logic signed [COORD_BITS-1:0]         pos_y,
	input  logic signed [COORD_BITS-1:0]         pos_z,
	input  logic                                 last_atom,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tpdbf_pkg::IDX_OUT_W-1:0]      first_atom,
	output logic [tpdbf_pkg::IDX_OUT_W-1:0]      second_atom,
	output logic [tpdbf_pkg::TYPE_W-1:0]         bond_kind,
	output logic [tpdbf_pkg::NUM_W-1:0]          bond_number,
	output logic                                 last_of_run
);

	localparam int IW = $clog2(MAX_ATOMS);
	localparam int OW = tpdbf_pkg::IDX_OUT_W;
	localparam int TW = tpdbf_pkg::TYPE_W;
	localparam int NW = tpdbf_pkg::NUM_W;
	localparam int RW = tpdbf_pkg::RAD_W;
	localparam logic [IW-1:0] LAST_STEP = IW'(MAX_ATOMS - 1);
	localparam logic [IW:0]   FULL      = (IW + 1)'(MAX_ATOMS);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DRAIN,
		FLUSH
	} state_t;

	state_t         state_q;
	logic [IW-1:0]  step_q;
	logic [1:0]     drain_q;
	logic [IW:0]    count_q;
	logic [NW-1:0]  bond_count_q;

	logic [TW-1:0]  kind_q;
	logic [TW-1:0]  type_a_q;
	logic [TW-1:0]  type_b_q;
	logic [RW-1:0]  min_q;
	logic [RW-1:0]  max_q;
	logic [2*RW-1:0] lo_sq_q;
	logic [2*RW-1:0] hi_sq_q;

	logic [TW-1:0]                new_type_q;
	logic signed [COORD_BITS-1:0] new_x_q;
	logic signed [COORD_BITS-1:0] new_y_q;
	logic signed [COORD_BITS-1:0] new_z_q;
	logic                         new_last_q;

	logic           pend_v_q;
	logic [OW-1:0]  pend_first_q;
	logic [NW-1:0]  pend_num_q;

	logic           out_valid_q;
	logic [OW-1:0]  out_first_q;
	logic [OW-1:0]  out_second_q;
	logic [NW-1:0]  out_num_q;
	logic           out_last_q;

	logic                         adv;
	logic                         shift_en;
	logic                         insert;
	logic                         feed;
	logic                         hit_s3;
	logic [IW-1:0]                idx_s3;
	logic [IW+OW-1:0]             first_ext;
	logic [IW+OW:0]               second_ext;
	logic [NW-1:0]                next_num;
	logic                         flush_out;
	logic                         hit_out;

	logic [TW-1:0]                cell_type [MAX_ATOMS];
	logic signed [COORD_BITS-1:0] cell_x    [MAX_ATOMS];
	logic signed [COORD_BITS-1:0] cell_y    [MAX_ATOMS];
	logic signed [COORD_BITS-1:0] cell_z    [MAX_ATOMS];

	assign adv        = !out_valid_q || out_ready;
	assign shift_en   = (state_q == SCAN) && adv;
	assign insert     = ({1'b0, step_q} == count_q);
	assign feed       = (state_q == SCAN) && ({1'b0, step_q} < count_q);
	assign first_ext  = {{OW{1'b0}}, idx_s3};
	assign second_ext = {{OW{1'b0}}, count_q};
	assign next_num   = (bond_count_q == tpdbf_pkg::BOND_MAX) ? bond_count_q
		: bond_count_q + NW'(1);
	assign flush_out  = (state_q == FLUSH) && adv && pend_v_q;
	assign hit_out    = adv && hit_s3 && pend_v_q;

	// ring of cells, the head cell feeds the pair test
	for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_ring
		if (i == MAX_ATOMS - 1) begin : g_tail
			tpdbf_cell #(.COORD_BITS(COORD_BITS)) u_cell (
				.clk    (clk),
				.en     (shift_en),
				.d_type (insert ? new_type_q : cell_type[0]),
				.d_x    (insert ? new_x_q : cell_x[0]),
				.d_y    (insert ? new_y_q : cell_y[0]),
				.d_z    (insert ? new_z_q : cell_z[0]),
				.q_type (cell_type[i]),
				.q_x    (cell_x[i]),
				.q_y    (cell_y[i]),
				.q_z    (cell_z[i])
			);
		end else begin : g_body
			tpdbf_cell #(.COORD_BITS(COORD_BITS)) u_cell (
				.clk    (clk),
				.en     (shift_en),
				.d_type (cell_type[i+1]),
				.d_x    (cell_x[i+1]),
				.d_y    (cell_y[i+1]),
				.d_z    (cell_z[i+1]),
				.q_type (cell_type[i]),
				.q_x    (cell_x[i]),
				.q_y    (cell_y[i]),
				.q_z    (cell_z[i])
			);
		end
	end

	tpdbf_dist #(.COORD_BITS(COORD_BITS), .IW(IW)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid     (feed),
		.idx       (step_q),
		.head_type (cell_type[0]),
		.head_x    (cell_x[0]),
		.head_y    (cell_y[0]),
		.head_z    (cell_z[0]),
		.new_type  (new_type_q),
		.new_x     (new_x_q),
		.new_y     (new_y_q),
		.new_z     (new_z_q),
		.type_a    (type_a_q),
		.type_b    (type_b_q),
		.lo_sq     (lo_sq_q),
		.hi_sq     (hi_sq_q),
		.hit_s3    (hit_s3),
		.idx_s3    (idx_s3)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			type_a_q <= '0;
			type_b_q <= '0;
			min_q    <= '0;
			max_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpdbf_pkg::CFG_BOND_KIND:  kind_q   <= cfg_data[TW-1:0];
				tpdbf_pkg::CFG_TYPE_A:     type_a_q <= cfg_data[TW-1:0];
				tpdbf_pkg::CFG_TYPE_B:     type_b_q <= cfg_data[TW-1:0];
				tpdbf_pkg::CFG_MIN_RADIUS: min_q    <= cfg_data;
				tpdbf_pkg::CFG_MAX_RADIUS: max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// squared radii
	always_ff @(posedge clk) begin
		lo_sq_q <= min_q * min_q;
		hi_sq_q <= max_q * max_q;
	end

	// incoming atom
	always_ff @(posedge clk) begin
		if (state_q == IDLE && in_valid) begin
			new_type_q <= atom_type;
			new_x_q    <= pos_x;
			new_y_q    <= pos_y;
			new_z_q    <= pos_z;
			new_last_q <= last_atom;
		end
	end

	// sequencer, held bond and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			step_q       <= '0;
			drain_q      <= '0;
			count_q      <= '0;
			bond_count_q <= '0;
			pend_v_q     <= 1'b0;
			pend_first_q <= '0;
			pend_num_q   <= '0;
			out_valid_q  <= 1'b0;
			out_first_q  <= '0;
			out_second_q <= '0;
			out_num_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (flush_out || hit_out) begin
				out_valid_q  <= 1'b1;
				out_first_q  <= pend_first_q;
				out_second_q <= second_ext[OW-1:0];
				out_num_q    <= pend_num_q;
				out_last_q   <= flush_out;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						if (count_q == FULL) begin
							if (last_atom) begin
								count_q <= '0;
							end
						end else begin
							state_q <= SCAN;
							step_q  <= '0;
						end
					end
				end
				SCAN: begin
					if (adv) begin
						if (step_q == LAST_STEP) begin
							state_q <= DRAIN;
							drain_q <= '0;
						end else begin
							step_q <= step_q + IW'(1);
						end
					end
				end
				DRAIN: begin
					if (adv) begin
						if (drain_q == 2'd2) begin
							state_q <= FLUSH;
						end else begin
							drain_q <= drain_q + 2'd1;
						end
					end
				end
				FLUSH: begin
					if (adv) begin
						state_q <= IDLE;
						count_q <= new_last_q ? '0 : count_q + (IW + 1)'(1);
						if (pend_v_q) begin
							pend_v_q <= 1'b0;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
			if (adv && hit_s3) begin
				pend_v_q     <= 1'b1;
				pend_first_q <= first_ext[OW-1:0];
				pend_num_q   <= next_num;
				bond_count_q <= next_num;
			end
		end
	end

	assign in_ready    = (state_q == IDLE);
	assign out_valid   = out_valid_q;
	assign first_atom  = out_first_q;
	assign second_atom = out_second_q;
	assign bond_kind   = kind_q;
	assign bond_number = out_num_q;
	assign last_of_run = out_last_q;

endmodule

@@ rtl/core/tpdbf_cell.sv @@
// one cell of the atom ring: holds a stored atom and passes it to its neighbor
module tpdbf_cell #(
	parameter int COORD_BITS = tpdbf_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tpdbf_pkg::TYPE_W-1:0]  d_type,
	input  logic signed [COORD_BITS-1:0]  d_x,
	input  logic signed [COORD_BITS-1:0]  d_y,
	input  logic signed [COORD_BITS-1:0]  d_z,
	output logic [tpdbf_pkg::TYPE_W-1:0]  q_type,
	output logic signed [COORD_BITS-1:0]  q_x,
	output logic signed [COORD_BITS-1:0]  q_y,
	output logic signed [COORD_BITS-1:0]  q_z
);

	logic [tpdbf_pkg::TYPE_W-1:0] type_q;
	logic signed [COORD_BITS-1:0] x_q;
	logic signed [COORD_BITS-1:0] y_q;
	logic signed [COORD_BITS-1:0] z_q;

	always_ff @(posedge clk) begin
		if (en) begin
			type_q <= d_type;
			x_q    <= d_x;
			y_q    <= d_y;
			z_q    <= d_z;
		end
	end

	assign q_type = type_q;
	assign q_x    = x_q;
	assign q_y    = y_q;
	assign q_z    = z_q;

endmodule

@@ rtl/core/tpdbf_dist.sv @@
// three-stage pair test: type match, squared distance and radius window
module tpdbf_dist #(
	parameter int COORD_BITS = tpdbf_pkg::COORD_BITS_DEF,
	parameter int IW         = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              valid,
	input  logic [IW-1:0]                     idx,
	input  logic [tpdbf_pkg::TYPE_W-1:0]      head_type,
	input  logic signed [COORD_BITS-1:0]      head_x,
	input  logic signed [COORD_BITS-1:0]      head_y,
	input  logic signed [COORD_BITS-1:0]      head_z,
	input  logic [tpdbf_pkg::TYPE_W-1:0]      new_type,
	input  logic signed [COORD_BITS-1:0]      new_x,
	input  logic signed [COORD_BITS-1:0]      new_y,
	input  logic signed [COORD_BITS-1:0]      new_z,
	input  logic [tpdbf_pkg::TYPE_W-1:0]      type_a,
	input  logic [tpdbf_pkg::TYPE_W-1:0]      type_b,
	input  logic [2*tpdbf_pkg::RAD_W-1:0]     lo_sq,
	input  logic [2*tpdbf_pkg::RAD_W-1:0]     hi_sq,
	output logic                              hit_s3,
	output logic [IW-1:0]                     idx_s3
);

	localparam int DFW = COORD_BITS + 1;
	localparam int SQW = 2 * DFW;
	localparam int DW  = SQW + 2;
	localparam int RW  = 2 * tpdbf_pkg::RAD_W;
	localparam int CW  = (DW > RW) ? DW : RW;

	logic                  v_s1;
	logic                  match_s1;
	logic [IW-1:0]         idx_s1;
	logic signed [DFW-1:0] dx_s1;
	logic signed [DFW-1:0] dy_s1;
	logic signed [DFW-1:0] dz_s1;

	logic                  v_s2;
	logic                  match_s2;
	logic [IW-1:0]         idx_s2;
	logic [SQW-1:0]        sx_s2;
	logic [SQW-1:0]        sy_s2;
	logic [SQW-1:0]        sz_s2;

	logic                  match;
	logic signed [DFW-1:0] dx;
	logic signed [DFW-1:0] dy;
	logic signed [DFW-1:0] dz;
	logic [DFW-1:0]        mx;
	logic [DFW-1:0]        my;
	logic [DFW-1:0]        mz;
	logic [DW-1:0]         d2;
	logic                  in_window;

	always_comb begin
		match = (head_type == type_a && new_type == type_b) ||
			(head_type == type_b && new_type == type_a);
		dx = DFW'(head_x) - DFW'(new_x);
		dy = DFW'(head_y) - DFW'(new_y);
		dz = DFW'(head_z) - DFW'(new_z);
		mx = dx_s1[DFW-1] ? DFW'(-dx_s1) : DFW'(dx_s1);
		my = dy_s1[DFW-1] ? DFW'(-dy_s1) : DFW'(dy_s1);
		mz = dz_s1[DFW-1] ? DFW'(-dz_s1) : DFW'(dz_s1);
		d2 = DW'(sx_s2) + DW'(sy_s2) + DW'(sz_s2);
		in_window = (CW'(d2) >= CW'(lo_sq)) && (CW'(d2) <= CW'(hi_sq));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			hit_s3 <= 1'b0;
		end else if (adv) begin
			v_s1   <= valid;
			v_s2   <= v_s1;
			hit_s3 <= v_s2 && match_s2 && in_window;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			match_s1 <= match;
			idx_s1   <= idx;
			dx_s1    <= dx;
			dy_s1    <= dy;
			dz_s1    <= dz;
			match_s2 <= match_s1;
			idx_s2   <= idx_s1;
			sx_s2    <= mx * mx;
			sy_s2    <= my * my;
			sz_s2    <= mz * mz;
			idx_s3   <= idx_s2;
		end
	end

endmodule
